FILE: src/bst_pkg.sv
// Shared types and codes for the breakpoint slot table.
`timescale 1ns / 1ps

package bst_pkg;

  typedef logic [2:0] action_t;
  typedef logic [1:0] status_t;

  localparam action_t ACT_FIND   = 3'd0;
  localparam action_t ACT_ALLOC  = 3'd1;
  localparam action_t ACT_STORE  = 3'd2;
  localparam action_t ACT_CLEAR  = 3'd3;
  localparam action_t ACT_SETEN  = 3'd4;
  localparam action_t ACT_READ   = 3'd5;

  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_MISS  = 2'd1;
  localparam status_t STAT_RANGE = 2'd2;

  localparam int SLOT_W = 6;
  localparam int ADDR_W = 16;
  localparam int PORT_IN_W = 8;
  localparam int PORT_W = 3;

  // port value of an empty slot
  localparam logic [PORT_W-1:0] PORT_EMPTY = 3'd7;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
  } slot_entry_t;

endpackage

FILE: src/breakpoint_slot_table.sv
// Breakpoint slot table: slot marks, address/port memory, scan sequencer.
`timescale 1ns / 1ps

// Channel   Direction  Ports
// in        input      in_valid, in_ready, in_action, in_slot, in_address, in_cpu_port,
//                      in_enable_value
// out       output     out_valid, out_ready, out_status, out_result_slot, out_slot_used,
//                      out_slot_enabled, out_slot_address, out_slot_cpu_port
//
// Sequencing: find/allocate walk every slot through one shared address comparator fed by the
//   slot memory's registered read port, stopping early on a hit. Indexed actions pass
//   through a read state first; a bad index or unknown action goes straight to the result.
// Reset: used and enabled marks clear at once; memory needs no clearing pass since an
//   unused slot always reads as address 0, port 7.
// Stalls: one word in flight; the finished result sits in the output register while the
//   next word is accepted, and the sequencer waits in its last state if that is still full.

module breakpoint_slot_table #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     in_action,
  input  logic [bst_pkg::SLOT_W-1:0]     in_slot,
  input  logic [bst_pkg::ADDR_W-1:0]     in_address,
  input  logic [bst_pkg::PORT_IN_W-1:0]  in_cpu_port,
  input  logic                           in_enable_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_status,
  output logic [bst_pkg::SLOT_W-1:0]     out_result_slot,
  output logic                           out_slot_used,
  output logic                           out_slot_enabled,
  output logic [bst_pkg::ADDR_W-1:0]     out_slot_address,
  output logic [bst_pkg::PORT_W-1:0]     out_slot_cpu_port
);
  import bst_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
  localparam logic [SLOT_W:0]  SLOT_LIM = (SLOT_W+1)'(SLOT_COUNT);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_IDXRD = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // captured word
  action_t             act_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [PORT_W-1:0]   port_r;
  logic                en_r;

  // marks live in flops so reset clears them at once
  logic [SLOT_COUNT-1:0] used_r, used_nxt;
  logic [SLOT_COUNT-1:0] enabled_r, enabled_nxt;

  // address/port memory, one write and one registered read per cycle
  slot_entry_t         mem [SLOT_COUNT];
  slot_entry_t         rd_q;
  logic [IDX_W-1:0]    rd_idx;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_wr_idx;
  slot_entry_t         mem_wr_data;

  // scan sequencer
  logic [IDX_W-1:0]    scan_idx_r, scan_idx_nxt;
  logic                issue_done_r, issue_done_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic                hit_r, hit_nxt;
  logic [IDX_W-1:0]    hit_idx_r, hit_idx_nxt;
  logic [PORT_W-1:0]   hit_port_r, hit_port_nxt;
  logic                free_r, free_nxt;
  logic [IDX_W-1:0]    free_idx_r, free_idx_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  status_t             status_r, status_nxt;
  logic [SLOT_W-1:0]   rslot_r, rslot_nxt;
  logic                oused_r, oused_nxt;
  logic                oen_r, oen_nxt;
  logic [ADDR_W-1:0]   oaddr_r, oaddr_nxt;
  logic [PORT_W-1:0]   oport_r, oport_nxt;

  logic                cmp_match;
  logic                cmp_last;
  logic [IDX_W-1:0]    slot_idx;
  logic                slot_used;

  assign in_ready  = (state_r == ST_IDLE);
  assign slot_idx  = slot_r[IDX_W-1:0];
  assign slot_used = used_r[slot_idx];
  assign rd_idx    = (state_r == ST_SCAN) ? scan_idx_r : slot_idx;

  // shared comparator on the slot read out last cycle
  assign cmp_match = cmp_vld_r && used_r[cmp_idx_r] && (rd_q.addr == addr_r);
  assign cmp_last  = cmp_vld_r && (cmp_idx_r == LAST_IDX);

  always_comb begin
    state_nxt      = state_r;
    scan_idx_nxt   = scan_idx_r;
    issue_done_nxt = issue_done_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = scan_idx_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_port_nxt   = hit_port_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    used_nxt       = used_r;
    enabled_nxt    = enabled_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    status_nxt     = status_r;
    rslot_nxt      = rslot_r;
    oused_nxt      = oused_r;
    oen_nxt        = oen_r;
    oaddr_nxt      = oaddr_r;
    oport_nxt      = oport_r;
    mem_we         = 1'b0;
    mem_wr_idx     = slot_idx;
    mem_wr_data    = '{addr: addr_r, port: port_r};

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_FIND || in_action == ACT_ALLOC) begin
            scan_idx_nxt   = '0;
            issue_done_nxt = 1'b0;
            hit_nxt        = 1'b0;
            free_nxt       = 1'b0;
            state_nxt      = ST_SCAN;
          end else if (in_action > ACT_READ || {1'b0, in_slot} >= SLOT_LIM) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_IDXRD;
          end
        end
      end

      ST_SCAN: begin
        if (cmp_match) begin
          hit_nxt      = 1'b1;
          hit_idx_nxt  = cmp_idx_r;
          hit_port_nxt = rd_q.port;
          state_nxt    = ST_DONE;
        end else begin
          // lowest unused slot is the allocation target
          if (cmp_vld_r && !used_r[cmp_idx_r] && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = cmp_idx_r;
          end
          if (cmp_last) begin
            state_nxt = ST_DONE;
          end else begin
            cmp_vld_nxt = !issue_done_r;
            cmp_idx_nxt = scan_idx_r;
            if (!issue_done_r) begin
              if (scan_idx_r == LAST_IDX) begin
                issue_done_nxt = 1'b1;
              end else begin
                scan_idx_nxt = scan_idx_r + 1'b1;
              end
            end
          end
        end
      end

      ST_IDXRD: begin
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          status_nxt    = STAT_OK;
          rslot_nxt     = slot_r;
          oused_nxt     = 1'b0;
          oen_nxt       = 1'b0;
          oaddr_nxt     = '0;
          oport_nxt     = '0;
          if (act_r == ACT_FIND || act_r == ACT_ALLOC) begin
            if (hit_r) begin
              rslot_nxt = SLOT_W'(hit_idx_r);
              oused_nxt = 1'b1;
              oen_nxt   = enabled_r[hit_idx_r];
              oaddr_nxt = addr_r;
              oport_nxt = hit_port_r;
            end else if (act_r == ACT_ALLOC && free_r) begin
              mem_we                  = 1'b1;
              mem_wr_idx              = free_idx_r;
              used_nxt[free_idx_r]    = 1'b1;
              enabled_nxt[free_idx_r] = 1'b1;
              rslot_nxt = SLOT_W'(free_idx_r);
              oused_nxt = 1'b1;
              oen_nxt   = 1'b1;
              oaddr_nxt = addr_r;
              oport_nxt = port_r;
            end else begin
              status_nxt = STAT_MISS;
              rslot_nxt  = '0;
            end
          end else if (act_r > ACT_READ) begin
            status_nxt = STAT_MISS;
            rslot_nxt  = '0;
          end else if ({1'b0, slot_r} >= SLOT_LIM) begin
            status_nxt = STAT_RANGE;
          end else begin
            case (act_r)
              ACT_STORE: begin
                mem_we                = 1'b1;
                used_nxt[slot_idx]    = 1'b1;
                enabled_nxt[slot_idx] = 1'b1;
                oused_nxt = 1'b1;
                oen_nxt   = 1'b1;
                oaddr_nxt = addr_r;
                oport_nxt = port_r;
              end
              ACT_CLEAR: begin
                // unused slot reads as empty, memory left as is
                used_nxt[slot_idx]    = 1'b0;
                enabled_nxt[slot_idx] = 1'b0;
                oport_nxt = PORT_EMPTY;
              end
              default: begin
                // set enable and read
                oused_nxt = slot_used;
                if (slot_used) begin
                  oaddr_nxt = rd_q.addr;
                  oport_nxt = rd_q.port;
                  if (act_r == ACT_SETEN) begin
                    enabled_nxt[slot_idx] = en_r;
                    oen_nxt = en_r;
                  end else begin
                    oen_nxt = enabled_r[slot_idx];
                  end
                end else begin
                  oport_nxt = PORT_EMPTY;
                end
              end
            endcase
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      enabled_r   <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      enabled_r   <= enabled_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_r  <= in_action;
      slot_r <= in_slot;
      addr_r <= in_address;
      port_r <= in_cpu_port[PORT_W-1:0];
      en_r   <= in_enable_value;
    end
    scan_idx_r   <= scan_idx_nxt;
    issue_done_r <= issue_done_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_port_r   <= hit_port_nxt;
    free_r       <= free_nxt;
    free_idx_r   <= free_idx_nxt;
    status_r     <= status_nxt;
    rslot_r      <= rslot_nxt;
    oused_r      <= oused_nxt;
    oen_r        <= oen_nxt;
    oaddr_r      <= oaddr_nxt;
    oport_r      <= oport_nxt;
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wr_idx] <= mem_wr_data;
    end
    rd_q <= mem[rd_idx];
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_result_slot   = rslot_r;
  assign out_slot_used     = oused_r;
  assign out_slot_enabled  = oen_r;
  assign out_slot_address  = oaddr_r;
  assign out_slot_cpu_port = oport_r;

endmodule

FILE: src/bst_checker.sv
// Port-level checks on the result channel of the breakpoint slot table.
`timescale 1ns / 1ps

module bst_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  out_status,
  input logic [bst_pkg::SLOT_W-1:0]  out_result_slot,
  input logic                        out_slot_used,
  input logic                        out_slot_enabled,
  input logic [bst_pkg::ADDR_W-1:0]  out_slot_address,
  input logic [bst_pkg::PORT_W-1:0]  out_slot_cpu_port
);
  import bst_pkg::*;

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_result_slot) && $stable(out_slot_address) && $stable(out_slot_cpu_port))
    else $error("result word changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_OK || out_status == STAT_MISS ||
                   out_status == STAT_RANGE))
    else $error("bad status code");

  a_miss_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_MISS |-> out_result_slot == '0 && !out_slot_used &&
    !out_slot_enabled && out_slot_address == '0 && out_slot_cpu_port == '0)
    else $error("miss word not blank");

  a_range_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_RANGE |-> !out_slot_used && !out_slot_enabled &&
    out_slot_address == '0 && out_slot_cpu_port == '0)
    else $error("out-of-range word not blank");

  // an unused slot always shows as empty
  a_unused_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_OK && !out_slot_used |-> !out_slot_enabled &&
    out_slot_address == '0 && out_slot_cpu_port == PORT_EMPTY)
    else $error("unused slot not empty");

endmodule

bind breakpoint_slot_table bst_checker u_bst_checker (.*);
